[rtl/zcfm_pkg.sv]
package zcfm_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int FREQ_W   = 32;
    localparam int CROSS_W  = 5;
    localparam int SUM_W    = 36;
    localparam int FRAC_W   = 16;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_TICK_RATE = 1'b0;
    localparam logic [APB_DATA_W-1:0] TICK_RATE_RESET = 32'd1000000;

    // default crossing cap
    localparam int MAX_CROSSINGS_DEF = 16;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

[rtl/zcfm_if.sv]
interface zcfm_in_if
    import zcfm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic        [TIME_W-1:0]   timestamp;
    logic                       last;

    modport source (output valid, output sample, output timestamp, output last, input ready);
    modport sink   (input valid, input sample, input timestamp, input last, output ready);
endinterface

interface zcfm_out_if
    import zcfm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FREQ_W-1:0]  frequency_q16;
    logic               valid_res;
    logic [CROSS_W-1:0] crossings;

    modport source (output valid, output frequency_q16, output valid_res, output crossings,
                    input ready);
    modport sink   (input valid, input frequency_q16, input valid_res, input crossings,
                    output ready);
endinterface

[rtl/zero_crossing_frequency_meter_top.sv]
// Zero-crossing frequency meter.
// samples: one request per voltage sample (signed sample, timestamp, last flag).
// results: one request per buffer, issued after the sample marked last, carrying
//   the frequency in unsigned Q16.16 Hz, a valid flag and the crossing count.
// APB port: register 0 at byte address 0 holds tick_rate_hz (reset 1000000).
// Throughput: a sample without last is taken every cycle while the sequencer is
//   idle. A last sample starts the frequency calculation: the multiply of tick rate
//   by (n - 1), then a restoring divider that retires one quotient bit per cycle
//   over the 48 + clog2(MAX_CROSSINGS) bit numerator (52 bits at the default cap
//   of 16), then a final step that loads the result. samples.ready is low meanwhile.
//   samples.ready rises again in the same cycle that results.valid rises.
// A finished result waits in an output register; further samples are taken
//   while it waits, but the next buffer's result holds in the final step until
//   the output register is free.
// Reset clears all crossing state, drops any pending result and restores the
//   tick rate. Buffer state also clears itself after every last sample.
module zero_crossing_frequency_meter_top
    import zcfm_pkg::*;
#(
    parameter int MAX_CROSSINGS = MAX_CROSSINGS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    zcfm_in_if.sink               samples,
    zcfm_out_if.source            results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W  = $clog2(MAX_CROSSINGS + 1);
    localparam int NM1_W  = $clog2(MAX_CROSSINGS);
    localparam int PROD_W = APB_DATA_W + NM1_W;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int DEN_W  = SUM_W + 1;
    localparam int DCNT_W = $clog2(NUM_W);

    state_t state_reg, state_next;

    // configuration register
    logic [APB_DATA_W-1:0] tick_rate_reg;
    logic                  cfg_wr;

    // buffer state
    logic signed [SAMPLE_W-1:0] prev_sample_reg;
    logic [TIME_W-1:0]          prev_time_reg;
    logic                       have_prev_reg;
    logic [CNT_W-1:0]           cross_cnt_reg;
    logic [TIME_W-1:0]          last_cross_reg;
    logic [SUM_W-1:0]           sum_reg;

    // calculation registers
    logic [CNT_W-1:0]  cnt_res_reg;
    logic [SUM_W-1:0]  sum_res_reg;
    logic              ok_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;

    // output register
    logic               out_valid_reg;
    logic [FREQ_W-1:0]  out_freq_reg;
    logic               out_ok_reg;
    logic [CROSS_W-1:0] out_cross_reg;

    logic accept;
    logic load_out;

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_TICK_RATE);
    assign prdata = (paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_TICK_RATE) ? tick_rate_reg
                                                                         : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= TICK_RATE_RESET;
        end
        else if (cfg_wr)
        begin
            tick_rate_reg <= pwdata;
        end
    end

    // crossing detection on the incoming sample
    logic signed [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W:0]          mag_prev, mag_cur;
    logic                       up, down, take;
    logic [TIME_W-1:0]          cross_time, delta;
    logic [SUM_W:0]             sum_add;
    logic [CNT_W-1:0]           cnt_next;
    logic [SUM_W-1:0]           sum_next;
    logic [TIME_W-1:0]          last_cross_next;

    always_comb
    begin
        cur      = samples.sample;
        mag_prev = prev_sample_reg[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, prev_sample_reg})
                                               : {1'b0, prev_sample_reg};
        mag_cur  = cur[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, cur}) : {1'b0, cur};
        up   = (prev_sample_reg[SAMPLE_W-1] || (prev_sample_reg == '0))
               && !cur[SAMPLE_W-1] && (cur != '0);
        down = !prev_sample_reg[SAMPLE_W-1] && cur[SAMPLE_W-1];
        take = have_prev_reg && (up || down) && (cross_cnt_reg < CNT_W'(MAX_CROSSINGS));
        cross_time = (mag_prev < mag_cur) ? prev_time_reg : samples.timestamp;
        delta = (cross_time >= last_cross_reg) ? (cross_time - last_cross_reg)
                                               : (last_cross_reg - cross_time);
        sum_add = {1'b0, sum_reg} + {{(SUM_W+1-TIME_W){1'b0}}, delta};

        cnt_next        = cross_cnt_reg;
        sum_next        = sum_reg;
        last_cross_next = last_cross_reg;
        if (take)
        begin
            cnt_next        = cross_cnt_reg + CNT_W'(1);
            last_cross_next = cross_time;
            if (cross_cnt_reg != '0)
            begin
                // saturate the half-period sum
                sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid && samples.last)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = samples.valid && samples.ready;

    // buffer state update, cleared after the last sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            prev_time_reg   <= '0;
            have_prev_reg   <= 1'b0;
            cross_cnt_reg   <= '0;
            last_cross_reg  <= '0;
            sum_reg         <= '0;
        end
        else if (accept)
        begin
            if (samples.last)
            begin
                prev_sample_reg <= '0;
                prev_time_reg   <= '0;
                have_prev_reg   <= 1'b0;
                cross_cnt_reg   <= '0;
                last_cross_reg  <= '0;
                sum_reg         <= '0;
            end
            else
            begin
                prev_sample_reg <= cur;
                prev_time_reg   <= samples.timestamp;
                have_prev_reg   <= 1'b1;
                cross_cnt_reg   <= cnt_next;
                last_cross_reg  <= last_cross_next;
                sum_reg         <= sum_next;
            end
        end
    end

    // shared divide step: shift in one numerator bit, trial subtract
    logic [DEN_W:0]    trial;
    logic              q_bit;
    logic [DEN_W:0]    trial_diff;
    logic [NM1_W-1:0]  n_minus_1;
    logic [CNT_W-1:0]  cnt_dec;
    logic [PROD_W-1:0] rate_prod;

    always_comb
    begin
        trial      = {rem_reg, num_reg[NUM_W-1]};
        q_bit      = (trial >= {1'b0, den_reg});
        trial_diff = trial - {1'b0, den_reg};
        cnt_dec    = cnt_res_reg - CNT_W'(1);
        n_minus_1  = cnt_dec[NM1_W-1:0];
        // full-width product of tick rate and (n - 1)
        rate_prod  = PROD_W'(tick_rate_reg) * PROD_W'(n_minus_1);
    end

    // calculation datapath
    always_ff @(posedge clk)
    begin
        if (accept && samples.last)
        begin
            cnt_res_reg <= cnt_next;
            sum_res_reg <= sum_next;
        end
        unique case (state_reg)
            ST_CALC:
            begin
                ok_reg      <= (cnt_res_reg >= CNT_W'(2)) && (sum_res_reg != '0);
                num_reg     <= {rate_prod, {FRAC_W{1'b0}}};
                den_reg     <= {sum_res_reg, 1'b0};
                rem_reg     <= '0;
                div_cnt_reg <= DCNT_W'(NUM_W - 1);
            end
            ST_DIV:
            begin
                num_reg     <= {num_reg[NUM_W-2:0], q_bit};
                rem_reg     <= q_bit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // result register
    logic [CNT_W+CROSS_W-1:0] cnt_wide;
    logic [FREQ_W-1:0]        freq_sat;

    always_comb
    begin
        cnt_wide = {{CROSS_W{1'b0}}, cnt_res_reg};
        freq_sat = (num_reg[NUM_W-1:FREQ_W] != '0) ? {FREQ_W{1'b1}} : num_reg[FREQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_freq_reg  <= ok_reg ? freq_sat : '0;
            out_ok_reg    <= ok_reg;
            out_cross_reg <= cnt_wide[CROSS_W-1:0];
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.frequency_q16 = out_freq_reg;
    assign results.valid_res     = out_ok_reg;
    assign results.crossings     = out_cross_reg;

endmodule

[sim/zcfm_frequency_check.sv]
module zcfm_frequency_check
    import zcfm_pkg::*;
#(
    parameter int MAX_CROSSINGS = MAX_CROSSINGS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    zcfm_in_if                    samples,
    zcfm_out_if                   results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    errors,
    output int                    pending
);

    localparam logic [SUM_W-1:0]  SUM_LIMIT  = {SUM_W{1'b1}};
    localparam logic [63:0]       FREQ_LIMIT = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [FREQ_W-1:0]  frequency_q16;
        logic               valid_res;
        logic [CROSS_W-1:0] crossings;
    } freq_result_t;

    // expected measurements, oldest first
    freq_result_t freq_expected_q[$];

    // shadow of the tick rate register and of the buffer state
    logic [APB_DATA_W-1:0]      tick_rate;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic [TIME_W-1:0]          prev_time;
    logic                       have_prev;
    int unsigned                cross_count;
    logic [TIME_W-1:0]          last_cross_time;
    logic [SUM_W-1:0]           half_period_sum;
    int                         mismatch_count = 0;

    function automatic logic [SAMPLE_W:0] magnitude(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W:0] wide;
        wide = v;
        return (wide < 0) ? -wide : wide;
    endfunction

    task automatic clear_buffer();
        prev_sample     = '0;
        prev_time       = '0;
        have_prev       = 1'b0;
        cross_count     = 0;
        last_cross_time = '0;
        half_period_sum = '0;
    endtask

    // add one crossing time to the half-period sum
    task automatic add_crossing(input logic [TIME_W-1:0] when);
        logic [TIME_W-1:0] span;
        logic [SUM_W:0]    wide_sum;
        if (cross_count < MAX_CROSSINGS)
        begin
            if (cross_count > 0)
            begin
                span = (when >= last_cross_time) ? when - last_cross_time
                                                 : last_cross_time - when;
                wide_sum = {1'b0, half_period_sum} + (SUM_W + 1)'(span);
                half_period_sum = (wide_sum > {1'b0, SUM_LIMIT}) ? SUM_LIMIT
                                                                 : wide_sum[SUM_W-1:0];
            end
            last_cross_time = when;
            cross_count++;
        end
    endtask

    // crossing detection per sample, frequency on the last one
    task automatic measure_sample(input logic signed [SAMPLE_W-1:0] cur,
                                  input logic [TIME_W-1:0] stamp, input logic is_last);
        logic         rising;
        logic         falling;
        logic [63:0]  numer;
        logic [63:0]  denom;
        logic [63:0]  quot;
        freq_result_t res;
        if (have_prev)
        begin
            rising  = (prev_sample <= 0) && (cur > 0);
            falling = (prev_sample >= 0) && (cur < 0);
            if (rising || falling)
                add_crossing((magnitude(prev_sample) < magnitude(cur)) ? prev_time : stamp);
        end
        prev_sample = cur;
        prev_time   = stamp;
        have_prev   = 1'b1;
        if (is_last)
        begin
            res.valid_res     = (cross_count >= 2) && (half_period_sum != '0);
            res.crossings     = CROSS_W'(cross_count);
            res.frequency_q16 = '0;
            if (res.valid_res)
            begin
                numer = (64'(tick_rate) * 64'(cross_count - 1)) << FRAC_W;
                denom = {27'b0, half_period_sum, 1'b0};
                quot  = numer / denom;
                res.frequency_q16 = (quot > FREQ_LIMIT) ? '1 : quot[FREQ_W-1:0];
            end
            freq_expected_q.push_back(res);
            clear_buffer();
        end
    endtask

    // compare one result request with the oldest expectation
    task automatic compare_result();
        freq_result_t want;
        if (freq_expected_q.size() == 0)
        begin
            mismatch_count++;
            $display("%0t unexpected result: expected none, actual freq %h valid %b crossings %0d",
                     $time, results.frequency_q16, results.valid_res, results.crossings);
        end
        else
        begin
            want = freq_expected_q.pop_front();
            if (results.frequency_q16 !== want.frequency_q16)
            begin
                mismatch_count++;
                $display("%0t frequency_q16 mismatch: expected %h actual %h",
                         $time, want.frequency_q16, results.frequency_q16);
            end
            if (results.valid_res !== want.valid_res)
            begin
                mismatch_count++;
                $display("%0t valid_res mismatch: expected %b actual %b",
                         $time, want.valid_res, results.valid_res);
            end
            if (results.crossings !== want.crossings)
            begin
                mismatch_count++;
                $display("%0t crossings mismatch: expected %0d actual %0d",
                         $time, want.crossings, results.crossings);
            end
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_buffer();
            tick_rate = TICK_RATE_RESET;
            freq_expected_q.delete();
        end
        else
        begin
            if (results.valid && results.ready)
                compare_result();
            if (samples.valid && samples.ready)
                measure_sample(samples.sample, samples.timestamp, samples.last);
            if (psel && penable && pready && (paddr[APB_ADDR_W-1:2] == REG_TICK_RATE))
            begin
                if (pwrite)
                    tick_rate = pwdata;
                else if (prdata !== tick_rate)
                begin
                    mismatch_count++;
                    $display("%0t tick_rate_hz read mismatch: expected %h actual %h",
                             $time, tick_rate, prdata);
                end
            end
        end
        errors  <= mismatch_count;
        pending <= freq_expected_q.size();
    end

endmodule

[sim/zero_crossing_frequency_meter_top_tb.sv]
module zero_crossing_frequency_meter_top_tb;
    import zcfm_pkg::*;

    localparam int CROSS_CAP    = MAX_CROSSINGS_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 6;
    localparam logic [APB_ADDR_W-1:0] ADDR_TICK_RATE = {REG_TICK_RATE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED    = {~REG_TICK_RATE, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    pending;
    int                    sent_items;
    bit                    burst_mode;

    zcfm_in_if  samples_if ();
    zcfm_out_if results_if ();

    zero_crossing_frequency_meter_top #(
        .MAX_CROSSINGS (CROSS_CAP)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    zcfm_frequency_check #(
        .MAX_CROSSINGS (CROSS_CAP)
    ) freq_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // one sample request, waits for acceptance
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                               input logic [TIME_W-1:0] stamp, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid     <= 1'b1;
        samples_if.sample    <= value;
        samples_if.timestamp <= stamp;
        samples_if.last      <= is_last;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        sent_items++;
    endtask

    // hold the sender until every pending measurement has come out
    task automatic wait_results_drained();
        samples_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // register write once the block is idle, then read back
    task automatic set_tick_rate(input logic [APB_DATA_W-1:0] rate);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_access(1'b1, ADDR_TICK_RATE, rate);
        apb_access(1'b0, ADDR_TICK_RATE, '0);
    endtask

    // level of one half wave, with zeros, extremes and small ties
    function automatic logic signed [SAMPLE_W-1:0] pick_level(input bit positive);
        int unsigned roll;
        int          mag;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return positive ? 16'sh7FFF : 16'sh8000;
        mag = (roll < 8) ? $urandom_range(1, 16) : $urandom_range(1, 32767);
        return positive ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
    endfunction

    // next timestamp: equal, small steps, big jumps, slight step back
    function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] stamp);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return stamp + $urandom_range(0, 3);
        else if (roll < 85)
            return stamp + $urandom_range(1, 2000);
        else if (roll < 95)
            return stamp + $urandom();
        else
            return stamp - $urandom_range(0, 50);
    endfunction

    // one buffer: mostly a square-ish wave, sometimes pure noise
    task automatic send_random_buffer();
        int                  len;
        int                  half;
        int                  run;
        int unsigned         roll;
        bit                  noise;
        bit                  positive;
        logic signed [SAMPLE_W-1:0] value;
        logic [TIME_W-1:0]   stamp;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            len = 1;
        else if (roll < 15)
            len = $urandom_range(34, 60);
        else
            len = $urandom_range(2, 24);
        noise    = ($urandom_range(0, 9) == 0);
        half     = $urandom_range(1, 5);
        positive = 1'($urandom_range(0, 1));
        run      = 0;
        stamp    = $urandom();
        for (int i = 0; i < len; i++)
        begin
            if (noise)
                value = SAMPLE_W'($urandom());
            else
            begin
                if (run >= half)
                begin
                    positive = !positive;
                    run      = 0;
                    if ($urandom_range(0, 3) == 0)
                        half = $urandom_range(1, 5);
                end
                value = pick_level(positive);
                run++;
            end
            send_sample(value, stamp, i == len - 1);
            stamp = next_stamp(stamp);
        end
    endtask

    // directed buffers: lone sample, edge cases, crossing cap
    task automatic send_directed();
        send_sample(16'sd0, 32'd0, 1'b1);

        send_sample(16'sd0, 32'd0, 1'b0);
        send_sample(16'sd0, 32'd5, 1'b0);
        send_sample(16'sh8000, 32'd10, 1'b0);
        send_sample(16'sh7FFF, 32'd20, 1'b0);
        send_sample(16'sd0, 32'd30, 1'b0);
        send_sample(-16'sd5, 32'd40, 1'b0);
        send_sample(16'sd100, 32'd12, 1'b0);
        send_sample(-16'sd100, 32'd3, 1'b1);

        for (int i = 0; i < 18; i++)
            send_sample((i % 2 == 0) ? 16'sh7FFF : 16'sh8000,
                        ((i / 2) % 2 == 1) ? 32'hFFFF_FFFF : 32'd0, i == 17);
    endtask

    // result side ready with random stalls
    initial
    begin
        results_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            int gap;
            results_if.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any accepted request
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        logic [APB_DATA_W-1:0] phase_rate [PHASES];
        int                    phase_end;
        phase_rate[0] = 32'd1;
        phase_rate[1] = 32'hFFFF_FFFF;
        phase_rate[2] = 32'd0;
        phase_rate[3] = 32'd48000;
        phase_rate[4] = $urandom();
        phase_rate[5] = TICK_RATE_RESET;

        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        samples_if.valid     <= 1'b0;
        samples_if.sample    <= '0;
        samples_if.timestamp <= '0;
        samples_if.last      <= 1'b0;
        sent_items           = 0;
        burst_mode           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the tick rate, then edge cases at that rate
        apb_access(1'b0, ADDR_TICK_RATE, '0);
        send_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            set_tick_rate(phase_rate[p]);
            if (p == 2)
            begin
                // write to an unmapped register, tick rate must stay
                apb_access(1'b1, ADDR_UNUSED, $urandom());
                apb_access(1'b0, ADDR_TICK_RATE, '0);
            end
            burst_mode = (p % 3 == 1);
            phase_end  = sent_items + RANDOM_ITEMS / PHASES;
            while (sent_items < phase_end)
            begin
                send_random_buffer();
                if ($urandom_range(0, 7) == 0)
                    burst_mode = !burst_mode;
                if ($urandom_range(0, 9) == 0)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/zcfm_pkg.sv
rtl/zcfm_if.sv
rtl/zero_crossing_frequency_meter_top.sv
sim/zcfm_frequency_check.sv
sim/zero_crossing_frequency_meter_top_tb.sv
